### rtl/sod_pkg.sv
// shared types and constants for the sub oscillator divider
package sod_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;
  localparam int OCTAVES_W   = 3;
  localparam int WAVE_W      = 2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [OCTAVES_W-1:0]   octaves_t;
  typedef logic [WAVE_W-1:0]      wave_sel_t;

  // register indexes
  localparam cfg_index_t REG_SUB_OCTAVES = 2'd0;
  localparam cfg_index_t REG_WAVE_SELECT = 2'd1;

  // shape codes
  localparam wave_sel_t WAVE_TRIANGLE = 2'd0;
  localparam wave_sel_t WAVE_PULSE_25 = 2'd1;
  localparam wave_sel_t WAVE_SQUARE   = 2'd2;

  localparam octaves_t  SUB_OCTAVES_RESET = 3'd1;
  localparam wave_sel_t WAVE_SELECT_RESET = WAVE_TRIANGLE;

endpackage

### rtl/sod_phase_if.sv
// stream channel carrying one master phase sample per transfer
interface sod_phase_if #(
  parameter int PHASE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase_in;

  modport source (output valid, output phase_in, input ready);
  modport sink   (input valid, input phase_in, output ready);
endinterface

### rtl/sod_sample_if.sv
// stream channel carrying one signed sub oscillator sample per transfer
interface sod_sample_if #(
  parameter int PHASE_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [PHASE_BITS:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/sub_oscillator_divider.sv
// sub oscillator divider: wrap counter, phase divide and wave shaping
// an input transfer is registered in the phase register, then in the result register
// throughput: one item per cycle; the wrap compare and counter step are combinational
// a stalled result holds both stages; a new item still enters while the first stage is free
// reset (synchronous, rst_n low): pipeline emptied, prev phase and wrap count cleared,
// sub_octaves back to 1 and wave_select back to triangle
module sub_oscillator_divider #(
  parameter int PHASE_BITS  = 16,
  parameter int MAX_OCTAVES = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sod_phase_if.sink             in_if,
  sod_sample_if.source          out_if,
  input  logic                  cfg_we,
  input  sod_pkg::cfg_index_t   cfg_index,
  input  sod_pkg::cfg_data_t    cfg_data
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int UNW_W = MAX_OCTAVES + PHASE_BITS;
  localparam logic signed [PHASE_BITS+1:0] HALF =
    {2'b00, 1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic signed [PHASE_BITS+1:0] QUARTER = HALF >>> 1;

  // configuration
  sod_pkg::octaves_t  sub_octaves_r;
  sod_pkg::wave_sel_t wave_select_r;

  // state
  logic [PHASE_BITS-1:0]  prev_phase_r;
  logic [MAX_OCTAVES-1:0] wrap_count_r;

  // stage 1: divided phase
  logic                   s1_valid_r;
  logic [PHASE_BITS-1:0]  x_r;
  sod_pkg::wave_sel_t     s1_wave_r;

  // stage 2: result
  logic                       out_valid_r;
  logic signed [PHASE_BITS:0] sample_r;

  logic                       out_en;
  logic                       s1_en;
  logic                       in_xfer;
  logic [OCT_W-1:0]           oct_eff;
  logic [MAX_OCTAVES-1:0]     cmask;
  logic [MAX_OCTAVES-1:0]     wrap_inc;
  logic [MAX_OCTAVES-1:0]     wrap_count_nxt;
  logic [UNW_W-1:0]           unwrapped;
  logic [PHASE_BITS-1:0]      x_nxt;
  logic signed [PHASE_BITS+1:0] xs;
  logic signed [PHASE_BITS+1:0] abs_dev;
  logic signed [PHASE_BITS+1:0] tri_val;
  logic signed [PHASE_BITS:0]   sample_nxt;

  assign out_en       = !out_valid_r || out_if.ready;
  assign s1_en        = !s1_valid_r || out_en;
  assign in_if.ready  = s1_en;
  assign in_xfer      = in_if.valid && s1_en;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = sample_r;

  // divide path
  always_comb begin
    if (32'(sub_octaves_r) > MAX_OCTAVES) begin
      oct_eff = OCT_W'(MAX_OCTAVES);
    end else begin
      oct_eff = OCT_W'(sub_octaves_r);
    end
    cmask          = ~({MAX_OCTAVES{1'b1}} << oct_eff);
    wrap_inc       = MAX_OCTAVES'(in_if.phase_in < prev_phase_r);
    // stored count may exceed the divisor after a lower setting, so mask before the step
    wrap_count_nxt = ((wrap_count_r & cmask) + wrap_inc) & cmask;
    unwrapped      = {wrap_count_nxt, in_if.phase_in};
    x_nxt          = PHASE_BITS'(unwrapped >> oct_eff);
  end

  // shaping path
  always_comb begin
    xs = {2'b00, x_r};
    if (xs >= HALF) begin
      abs_dev = xs - HALF;
    end else begin
      abs_dev = HALF - xs;
    end
    tri_val = (abs_dev <<< 1) - HALF;
    case (s1_wave_r)
      sod_pkg::WAVE_TRIANGLE: sample_nxt = tri_val[PHASE_BITS:0];
      sod_pkg::WAVE_PULSE_25: sample_nxt = (xs >= QUARTER) ? HALF[PHASE_BITS:0]
                                                           : -HALF[PHASE_BITS:0];
      sod_pkg::WAVE_SQUARE:   sample_nxt = (xs >= HALF) ? HALF[PHASE_BITS:0]
                                                        : -HALF[PHASE_BITS:0];
      default:                sample_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_octaves_r <= sod_pkg::SUB_OCTAVES_RESET;
      wave_select_r <= sod_pkg::WAVE_SELECT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sod_pkg::REG_SUB_OCTAVES: sub_octaves_r <= cfg_data[sod_pkg::OCTAVES_W-1:0];
        sod_pkg::REG_WAVE_SELECT: wave_select_r <= cfg_data[sod_pkg::WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_phase_r <= '0;
      wrap_count_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_phase_r <= in_if.phase_in;
        wrap_count_r <= wrap_count_nxt;
      end
      if (s1_en) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r       <= x_nxt;
      s1_wave_r <= wave_select_r;
    end
    if (out_en && s1_valid_r) begin
      sample_r <= sample_nxt;
    end
  end

endmodule

### rtl/sod_checker.sv
// port level checks for the sub oscillator divider
module sod_checker #(
  parameter int PHASE_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [PHASE_BITS:0] sample_out
);

  localparam logic signed [PHASE_BITS:0] HALF = {2'b01, {(PHASE_BITS-1){1'b0}}};

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

  // samples stay within minus to plus one half
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sample_out <= HALF) && (sample_out >= -HALF))
    else $error("sample out of range");

  // with the result side free the input is never blocked
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // draining with no input transfer through both stages leaves nothing behind
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_xfer && out_ready) ##1 (!in_xfer && out_ready) |=> !out_valid)
    else $error("result appeared without an input transfer");

endmodule

bind sub_oscillator_divider sod_checker #(.PHASE_BITS(PHASE_BITS)) u_sod_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .sample_out (out_if.sample_out)
);
